@@ src/skvb_pkg.sv @@
// Package for the sorted key/value buffer: shared constants, codes, channel items and
// control structs. No dependencies; every other file of the block but the channel interface imports it.
package skvb_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BITS_DEF = 32;
  localparam int VAL_BITS_DEF = 32;
  localparam int CAP_REG_BITS = 6;
  localparam int TOMB_BITS    = 32;
  localparam int STATUS_BITS  = 3;
  localparam int REQ_BITS     = 2;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [REQ_BITS-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_GET   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_RANGE = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_STORED      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FOUND       = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_DELETED     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_MISSING     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_RANGE_ENTRY = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_RANGE_EMPTY = 3'd6;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_CAPACITY  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_TOMBSTONE = 3'd4;

  // Request and response items as they travel on the two channels.
  typedef struct packed {
    logic [REQ_BITS-1:0] req_type;
    logic [31:0]         key;
    logic [31:0]         value;
    logic [31:0]         key_high;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [31:0]            out_key;
    logic [31:0]            out_value;
    logic                   is_last;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // register the accepted request
    logic insert;     // shift-insert the captured key at the lower index
    logic overwrite;  // overwrite the value at the lower index
    logic scan_load;  // load the range cursor with the lower index
    logic scan_step;  // advance the range cursor
  } skvb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;         // key at lower index equals the request key
    logic full;        // count has reached the limit
    logic scan_valid;  // cursor points at an in-range entry
    logic scan_next;   // entry after the cursor is in range too
  } skvb_stat_t;

endpackage

@@ src/skvb_if.sv @@
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
interface skvb_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/sorted_kv_buffer_with_tombstones.sv @@
// Sorted key/value buffer with deletion marks. A put or get request passes through the
// put or get state into the result register; the block turns idle at the edge that
// takes the last result item, so one request is in flight at a time.
// A range request passes through the cursor-loading range state before its first
// item, then presents one item per cycle while rsp.ready holds.
// Synchronous active-high reset empties the buffer and restores both registers.
module sorted_kv_buffer_with_tombstones #(
  parameter int CAPACITY = skvb_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = skvb_pkg::KEY_BITS_DEF,
  parameter int VAL_BITS = skvb_pkg::VAL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  skvb_if.sink   req,
  skvb_if.source rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [skvb_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import skvb_pkg::*;
  localparam int CW = $clog2(CAPACITY+1);

  // Configuration registers.
  logic [CAP_REG_BITS-1:0] capacity_limit;
  logic [TOMB_BITS-1:0]    tombstone_value;
  logic [CW-1:0]           limit;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit  <= CAP_REG_BITS'(32);
      tombstone_value <= '1;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_CAPACITY)  capacity_limit  <= pwdata[CAP_REG_BITS-1:0];
      if (paddr == ADDR_TOMBSTONE) tombstone_value <= pwdata;
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CAPACITY)  prdata = 32'(capacity_limit);
    if (paddr == ADDR_TOMBSTONE) prdata = tombstone_value;
  end

  // The register limit saturates at the physical capacity.
  always_comb begin
    if (32'(capacity_limit) > 32'(CAPACITY)) limit = CW'(CAPACITY);
    else limit = CW'(capacity_limit);
  end

  skvb_cmd_t  cmd;
  skvb_stat_t stat;
  logic [KEY_BITS-1:0] cur_key;
  logic [VAL_BITS-1:0] cur_value, hit_value;

  skvb_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VAL_BITS(VAL_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_key(KEY_BITS'(req.data.key)), .in_value(VAL_BITS'(req.data.value)),
    .in_key_high(KEY_BITS'(req.data.key_high)), .limit,
    .cur_key, .cur_value, .hit_value
  );

  logic [KEY_BITS-1:0] o_key;
  logic [VAL_BITS-1:0] o_value;

  // The controller holds the result register that drives the response channel.
  skvb_ctrl #(.KEY_BITS(KEY_BITS), .VAL_BITS(VAL_BITS)) u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready), .in_req(req.data.req_type),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_status(rsp.data.status),
    .out_key(o_key), .out_value(o_value), .out_last(rsp.data.is_last),
    .cmd, .stat, .cur_key, .cur_value, .hit_value, .tombstone(tombstone_value)
  );
  assign rsp.data.out_key   = 32'(o_key);
  assign rsp.data.out_value = 32'(o_value);
endmodule

@@ src/skvb_datapath.sv @@
// Datapath of the sorted key/value buffer: key/value register arrays, parallel compare,
// shift insert and the range cursor. Depends on skvb_pkg.
module skvb_datapath #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 32,
  parameter int VAL_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  skvb_pkg::skvb_cmd_t        cmd,
  output skvb_pkg::skvb_stat_t       stat,
  input  logic [KEY_BITS-1:0]        in_key,
  input  logic [VAL_BITS-1:0]        in_value,
  input  logic [KEY_BITS-1:0]        in_key_high,
  input  logic [$clog2(CAPACITY+1)-1:0] limit,
  output logic [KEY_BITS-1:0]        cur_key,
  output logic [VAL_BITS-1:0]        cur_value,
  output logic [VAL_BITS-1:0]        hit_value
);
  import skvb_pkg::*;
  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_BITS-1:0] keys [CAPACITY];
  logic [VAL_BITS-1:0] vals [CAPACITY];
  logic [CW-1:0] count;
  logic [KEY_BITS-1:0] req_key, req_key_high;
  logic [VAL_BITS-1:0] req_value;
  logic [CAPACITY-1:0] below;     // stored key < request key, per slot
  logic [CAPACITY-1:0] le_high;   // stored key <= high key, per slot
  logic [CW-1:0] lower;
  logic [CW-1:0] cursor;
  logic [IW-1:0] lower_ix, cursor_ix, next_ix;
  logic [CW-1:0] cursor_p1;

  always_comb begin
    for (int s = 0; s < CAPACITY; s++) begin
      below[s]   = (s < count) && (keys[s] < req_key);
      le_high[s] = keys[s] <= req_key_high;
    end
  end

  // Entries are sorted, so the lower index is the number of smaller keys.
  assign lower     = CW'($countones(below));
  assign lower_ix  = lower[IW-1:0];
  assign cursor_ix = cursor[IW-1:0];
  assign cursor_p1 = cursor + CW'(1);
  assign next_ix   = cursor_p1[IW-1:0];

  assign stat.hit  = (lower < count) && (keys[lower_ix] == req_key);
  assign stat.full = count >= limit;
  assign stat.scan_valid = (req_key <= req_key_high) && (cursor < count) && le_high[cursor_ix];
  assign stat.scan_next  = (cursor_p1 < count) && le_high[next_ix];
  assign cur_key   = keys[cursor_ix];
  assign cur_value = vals[cursor_ix];
  assign hit_value = vals[lower_ix];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end
    if (cmd.capture) begin
      req_key      <= in_key;
      req_value    <= in_value;
      req_key_high <= in_key_high;
    end
    if (cmd.scan_load) begin
      cursor <= lower;
    end else if (cmd.scan_step) begin
      cursor <= cursor_p1;
    end
    for (int s = 0; s < CAPACITY; s++) begin
      if (cmd.insert) begin
        if (s == lower) begin
          keys[s] <= req_key;
          vals[s] <= req_value;
        end else if (s > lower && s > 0) begin
          keys[s] <= keys[(s > 0) ? s-1 : 0];
          vals[s] <= vals[(s > 0) ? s-1 : 0];
        end
      end else if (cmd.overwrite && s == lower) begin
        vals[s] <= req_value;
      end
    end
  end
endmodule

@@ src/skvb_ctrl.sv @@
// Controller of the sorted key/value buffer: request sequencing and the result register.
// Depends on skvb_pkg.
module skvb_ctrl #(
  parameter int KEY_BITS = 32,
  parameter int VAL_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [skvb_pkg::REQ_BITS-1:0]     in_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [skvb_pkg::STATUS_BITS-1:0]  out_status,
  output logic [KEY_BITS-1:0]               out_key,
  output logic [VAL_BITS-1:0]               out_value,
  output logic                              out_last,
  output skvb_pkg::skvb_cmd_t               cmd,
  input  skvb_pkg::skvb_stat_t              stat,
  input  logic [KEY_BITS-1:0]               cur_key,
  input  logic [VAL_BITS-1:0]               cur_value,
  input  logic [VAL_BITS-1:0]               hit_value,
  input  logic [skvb_pkg::TOMB_BITS-1:0]    tombstone
);
  import skvb_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_PUT, S_GET, S_RANGE, S_SCAN, S_OUT} state_t;
  state_t state;
  logic out_free;
  logic tomb_hit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign tomb_hit = (TOMB_BITS >= VAL_BITS)
                    ? (TOMB_BITS'(hit_value) == tombstone)
                    : (hit_value == VAL_BITS'(tombstone));

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    unique case (state)
      S_PUT: begin
        cmd.overwrite = stat.hit;
        cmd.insert    = !stat.hit && !stat.full;
      end
      S_RANGE: cmd.scan_load = 1'b1;
      S_SCAN:  cmd.scan_step = out_free && stat.scan_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the scan state a taken item is always replaced by the next one below.
      if (out_valid && out_ready && state != S_SCAN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          unique case (in_req)
            REQ_PUT:   state <= S_PUT;
            REQ_GET:   state <= S_GET;
            REQ_RANGE: state <= S_RANGE;
            default:   state <= S_IDLE;
          endcase
        end
        S_PUT, S_GET: begin
          state      <= S_OUT;
          out_valid  <= 1'b1;
          out_key    <= '0;
          out_last   <= 1'b1;
          if (state == S_PUT) begin
            out_status <= (stat.hit || !stat.full) ? ST_STORED : ST_FULL;
            out_value  <= '0;
          end else if (!stat.hit) begin
            out_status <= ST_MISSING;
            out_value  <= '0;
          end else if (tomb_hit) begin
            out_status <= ST_DELETED;
            out_value  <= '0;
          end else begin
            out_status <= ST_FOUND;
            out_value  <= hit_value;
          end
        end
        S_RANGE: begin
          state <= S_SCAN;
          out_last <= 1'b0;
        end
        S_SCAN: if (out_free) begin
          out_valid <= 1'b1;
          if (stat.scan_valid) begin
            out_status <= ST_RANGE_ENTRY;
            out_key    <= cur_key;
            out_value  <= cur_value;
            out_last   <= !stat.scan_next;
            state      <= stat.scan_next ? S_SCAN : S_OUT;
          end else begin
            out_status <= ST_RANGE_EMPTY;
            out_key    <= '0;
            out_value  <= '0;
            out_last   <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/skvb_checker.sv @@
// Port-level checker for the sorted key/value buffer, bound to the top level.
// Depends on skvb_pkg.
module skvb_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [2:0] status,
  input logic is_last
);
  import skvb_pkg::*;
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_STORED || status == ST_FULL || status == ST_FOUND ||
      status == ST_DELETED || status == ST_MISSING || status == ST_RANGE_EMPTY)) |-> is_last)
    else $error("single result not marked last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)))
    else $error("stalled result changed");
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> $stable(is_last)) else $error("stalled last flag changed");
endmodule

bind sorted_kv_buffer_with_tombstones skvb_checker u_chk (
  .clk, .rst, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.data.status), .is_last(rsp.data.is_last)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the sorted key/value buffer with deletion marks.
// Depends on skvb_pkg, skvb_if and the sorted_kv_buffer_with_tombstones RTL.
`timescale 1ns / 1ps

module tb_top;
  import skvb_pkg::*;

  // The scoreboard holds its own copy of the buffer and both registers, works out
  // the responses of every accepted request and compares arriving responses in order.
  class kv_scoreboard;
    logic [31:0] mem_keys[CAPACITY_DEF];
    logic [31:0] mem_vals[CAPACITY_DEF];
    int unsigned count;
    logic [CAP_REG_BITS-1:0] cap_reg;
    logic [31:0] tomb_reg;
    rsp_item_t expected_rsps[$];
    int unsigned fails;

    function void clear();
      count = 0;
      cap_reg = 6'd32;
      tomb_reg = 32'hFFFF_FFFF;
      expected_rsps.delete();
      fails = 0;
    endfunction

    function int unsigned first_at_or_above(logic [31:0] k);
      int unsigned i;
      i = 0;
      while (i < count && mem_keys[i] < k) i++;
      return i;
    endfunction

    function void push_rsp(logic [STATUS_BITS-1:0] st, logic [31:0] k, logic [31:0] v,
                           logic last);
      rsp_item_t r;
      r.status = st;
      r.out_key = k;
      r.out_value = v;
      r.is_last = last;
      expected_rsps.push_back(r);
    endfunction

    function void note_request(req_item_t rq);
      int unsigned i, j, limit, n;
      limit = (cap_reg > CAPACITY_DEF) ? CAPACITY_DEF : cap_reg;
      case (rq.req_type)
        REQ_PUT: begin
          i = first_at_or_above(rq.key);
          if (i < count && mem_keys[i] == rq.key) begin
            mem_vals[i] = rq.value;
            push_rsp(ST_STORED, '0, '0, 1'b1);
          end else if (count >= limit) begin
            push_rsp(ST_FULL, '0, '0, 1'b1);
          end else begin
            for (j = count; j > i; j--) begin
              mem_keys[j] = mem_keys[j-1];
              mem_vals[j] = mem_vals[j-1];
            end
            mem_keys[i] = rq.key;
            mem_vals[i] = rq.value;
            count++;
            push_rsp(ST_STORED, '0, '0, 1'b1);
          end
        end
        REQ_GET: begin
          i = first_at_or_above(rq.key);
          if (i < count && mem_keys[i] == rq.key) begin
            if (mem_vals[i] == tomb_reg) push_rsp(ST_DELETED, '0, '0, 1'b1);
            else push_rsp(ST_FOUND, '0, mem_vals[i], 1'b1);
          end else begin
            push_rsp(ST_MISSING, '0, '0, 1'b1);
          end
        end
        REQ_RANGE: begin
          n = 0;
          if (rq.key <= rq.key_high) begin
            for (i = first_at_or_above(rq.key); i < count && mem_keys[i] <= rq.key_high;
                 i++) begin
              push_rsp(ST_RANGE_ENTRY, mem_keys[i], mem_vals[i], 1'b0);
              n++;
            end
          end
          if (n == 0) push_rsp(ST_RANGE_EMPTY, '0, '0, 1'b1);
          else expected_rsps[$].is_last = 1'b1;
        end
        default: ;  // unknown request types are dropped by the block
      endcase
    endfunction

    function void check_rsp(rsp_item_t got);
      rsp_item_t exp;
      if (expected_rsps.size() == 0) begin
        $error("unexpected response item: status %0d key %h value %h last %0d",
               got.status, got.out_key, got.out_value, got.is_last);
        fails++;
        return;
      end
      exp = expected_rsps.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        fails++;
      end
      if (got.out_key !== exp.out_key) begin
        $error("out_key: expected %h, actual %h", exp.out_key, got.out_key);
        fails++;
      end
      if (got.out_value !== exp.out_value) begin
        $error("out_value: expected %h, actual %h", exp.out_value, got.out_value);
        fails++;
      end
      if (got.is_last !== exp.is_last) begin
        $error("is_last: expected %0d, actual %0d", exp.is_last, got.is_last);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  skvb_if #(.payload_t(req_item_t)) req_ch ();
  skvb_if #(.payload_t(rsp_item_t)) rsp_ch ();

  sorted_kv_buffer_with_tombstones u_top (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kv_scoreboard sb = new();

  // Key pool: a small set of keys reused often so that puts hit stored keys,
  // the buffer fills up, and range bounds land on real entries.
  logic [31:0] key_pool[48];
  int unsigned burst_left = 0;

  always #5 clk = ~clk;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  // The receiver stalls on a pattern whose mode is picked at random, one of:
  // always ready, mostly ready, or mostly stalled.
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
      default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // Every response item accepted at a clock edge is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_rsp(rsp_ch.data);
  end

  // Sends one request item. The sender works in bursts; between most bursts valid drops
  // low for a random gap. Valid stays high from one item to the next in a burst.
  task automatic send_req(req_item_t rq);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.data <= rq;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(rq);
  endtask

  task automatic send_fields(logic [REQ_BITS-1:0] t, logic [31:0] k, logic [31:0] v,
                             logic [31:0] kh);
    req_item_t rq;
    rq.req_type = t;
    rq.key = k;
    rq.value = v;
    rq.key_high = kh;
    send_req(rq);
  endtask

  // Pauses the sender until every expected response has come, then lets the block
  // settle in case a dropped request is still in flight.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at the
  // edge that ends the access cycle.
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_CAPACITY) sb.cap_reg = data[CAP_REG_BITS-1:0];
    else sb.tomb_reg = data;
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return key_pool[$urandom_range(0, 47)];
    if (r < 80) return 32'h0;
    if (r < 85) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return sb.tomb_reg;
    if (r < 20) return 32'h0;
    if (r < 25) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Random traffic: mostly puts and gets on pooled keys, range queries with ordered
  // bounds most of the time, and a few reversed ranges and unknown request types.
  task automatic random_traffic(int unsigned n_items, bit pause_midway);
    int unsigned r, i;
    logic [31:0] a, b;
    for (i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) wait_drained();
      r = $urandom_range(0, 99);
      a = pick_key();
      b = pick_key();
      if (r < 45) begin
        send_fields(REQ_PUT, a, pick_value(), $urandom);
      end else if (r < 75) begin
        send_fields(REQ_GET, a, $urandom, $urandom);
      end else if (r < 95) begin
        if ($urandom_range(0, 9) < 8 && a > b) send_fields(REQ_RANGE, b, $urandom, a);
        else send_fields(REQ_RANGE, a, $urandom, b);
      end else begin
        send_fields(2'd3, a, $urandom, b);
      end
    end
  endtask

  initial begin
    int unsigned i;
    sb.clear();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (i = 2; i < 48; i++) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under reset register values: empty store, extreme keys,
    // a deletion mark, an overwrite, a full range, a reversed range, an unknown type.
    send_fields(REQ_GET, 32'h1234_5678, 32'h0, 32'h0);
    send_fields(REQ_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_fields(REQ_PUT, 32'h0, 32'h0, 32'h0);
    send_fields(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_fields(REQ_PUT, 32'h8000_0000, 32'hA5A5_5A5A, 32'h0);
    send_fields(REQ_GET, 32'h0, 32'h0, 32'h0);
    send_fields(REQ_GET, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_fields(REQ_PUT, 32'h0, 32'h5A5A_A5A5, 32'h0);
    send_fields(REQ_GET, 32'h0, 32'h0, 32'h0);
    send_fields(REQ_RANGE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_fields(REQ_RANGE, 32'h8000_0000, 32'h0, 32'h8000_0000);
    send_fields(REQ_RANGE, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_fields(REQ_RANGE, 32'h1, 32'h0, 32'h7FFF_FFFF);
    send_fields(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(REQ_GET, 32'h7, 32'h0, 32'h0);
    wait_drained();

    // Capacity of one while three keys are stored: new keys refused, overwrites kept.
    write_reg(ADDR_CAPACITY, 32'd1);
    write_reg(ADDR_TOMBSTONE, 32'h0);
    send_fields(REQ_PUT, 32'h42, 32'h1, 32'h0);
    send_fields(REQ_PUT, 32'h8000_0000, 32'h0, 32'h0);
    send_fields(REQ_GET, 32'h8000_0000, 32'h0, 32'h0);
    random_traffic(20, 1'b0);
    wait_drained();

    // Capacity zero: every new key is refused.
    write_reg(ADDR_CAPACITY, 32'd0);
    random_traffic(20, 1'b0);
    wait_drained();

    // Full capacity with the reset tombstone; the buffer fills from the key pool.
    write_reg(ADDR_CAPACITY, 32'd32);
    write_reg(ADDR_TOMBSTONE, 32'hFFFF_FFFF);
    random_traffic(80, 1'b1);
    wait_drained();

    // Capacity above the buffer size saturates; a random tombstone value.
    write_reg(ADDR_CAPACITY, 32'd63);
    write_reg(ADDR_TOMBSTONE, $urandom);
    random_traffic(50, 1'b0);
    wait_drained();

    // A middle capacity below the count, and a last stretch of traffic.
    write_reg(ADDR_CAPACITY, 32'd17);
    write_reg(ADDR_TOMBSTONE, key_pool[5]);
    random_traffic(40, 1'b0);
    wait_drained();

    if (sb.fails == 0 && sb.expected_rsps.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/skvb_pkg.sv
src/skvb_if.sv
src/skvb_datapath.sv
src/skvb_ctrl.sv
src/sorted_kv_buffer_with_tombstones.sv
src/skvb_checker.sv
dv/tb_top.sv
